// ===== sv/dense_dijkstra_shortest_path_top_macros.svh =====
// assertion macros for the dense dijkstra shortest path block
// used by dense_dijkstra_shortest_path_top, no other dependencies
`ifndef DENSE_DIJKSTRA_SHORTEST_PATH_TOP_MACROS_SVH
`define DENSE_DIJKSTRA_SHORTEST_PATH_TOP_MACROS_SVH

// same-cycle implication
`define DDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dds_pkg.sv =====
// shared types and constants of the dense dijkstra shortest path block
// no dependencies
`default_nettype none

package dds_pkg;

   localparam int DIST_W      = 22;
   localparam int PRED_W      = 6;
   localparam int VTX_W       = 7;
   localparam int IN_WEIGHT_W = 16;
   localparam int CSR_W       = 6;
   localparam int RES_DIST_W  = 21;

   localparam logic [DIST_W-1:0] DIST_INF = 22'h200000;
   localparam logic [DIST_W-1:0] DIST_MAX = 22'h1FFFFF;
   localparam logic [CSR_W-1:0]  VCOUNT_RESET = 6'd32;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_EDGE  = 2'd1,
      OP_RUN   = 2'd2,
      OP_QUERY = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_EDGE   = 2'd1,
      STAT_BAD_VERTEX = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_EDGE2,
      S_INIT,
      S_SCAN,
      S_RELAX,
      S_QUERY,
      S_RESULT
   } state_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [VTX_W-1:0]         vertex_a;
      logic [VTX_W-1:0]         vertex_b;
      logic [IN_WEIGHT_W-1:0]   edge_weight;
   } cmd_type;

   typedef struct packed {
      status_type               status;
      logic [RES_DIST_W-1:0]    path_distance;
      logic                     reachable;
      logic [PRED_W-1:0]        predecessor;
   } res_type;

   typedef struct packed {
      logic                     visited;
      logic [DIST_W-1:0]        cost;
      logic [PRED_W-1:0]        pred;
   } vtx_entry_type;

   typedef struct packed {
      logic                     cmd_ready;
      logic                     res_valid;
   } eng_stat_type;

endpackage

`default_nettype wire

// ===== sv/dds_ram.sv =====
// single write port, single read port synchronous memory with registered read data
// no dependencies
`default_nettype none

module dds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/dds_engine.sv =====
// command sequencer: adjacency matrix and vertex table in two memories,
// clear sweep, edge writes, dijkstra scan and relax passes, queries
// depends on dds_pkg and dds_ram
`default_nettype none

module dds_engine #(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                cmd_valid,
   input  wire dds_pkg::cmd_type                    cmd,
   input  wire logic [$clog2(MAX_VERTICES+1)-1:0]   vert_used,
   input  wire logic                                res_ack,
   output dds_pkg::eng_stat_type                    stat,
   output dds_pkg::res_type                         res
);

   import dds_pkg::*;

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int AW    = 2 * VW;
   localparam int ADJ_W = WEIGHT_BITS + 1;
   localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
   localparam int VTE_W = $bits(vtx_entry_type);
   localparam logic [ADJ_W-1:0] ADJ_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [VW-1:0] pidx_ff, pidx_in;
   logic          pvld_ff, pvld_in;
   logic [VW-1:0] src_ff, src_in;
   logic [VW-1:0] pick_ff, pick_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [CW-1:0] round_ff, round_in;
   logic [CW-1:0] runv_ff, runv_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          clr_rsp_ff, clr_rsp_in;
   res_type       res_ff, res_in;

   logic             adj_we;
   logic [AW-1:0]    adj_waddr, adj_raddr;
   logic [ADJ_W-1:0] adj_wdata, adj_rdata;
   logic             vtx_we;
   logic [VW-1:0]    vtx_waddr, vtx_raddr;
   vtx_entry_type    vtx_wdata, vtx_rd;
   logic [VTE_W-1:0] vtx_rdata;

   logic [VTX_W-1:0] v7, a_m1, b_m1;
   logic             edge_ok, src_ok, goal_ok, goal_run, issue, pass_done;
   logic [WEIGHT_BITS+IN_WEIGHT_W-1:0] w_wide;
   logic [WEIGHT_BITS-1:0] w_cmd, w_rd;
   logic             w_inf;
   logic [SUM_W-1:0] sum_full;
   logic [DIST_W-1:0] sum_sat, w_sat;

   dds_ram #(.WIDTH(ADJ_W), .DEPTH(1 << AW)) u_adj_ram (
      .clock (clock),
      .we    (adj_we),
      .waddr (adj_waddr),
      .wdata (adj_wdata),
      .raddr (adj_raddr),
      .rdata (adj_rdata)
   );

   dds_ram #(.WIDTH(VTE_W), .DEPTH(1 << VW)) u_vtx_ram (
      .clock (clock),
      .we    (vtx_we),
      .waddr (vtx_waddr),
      .wdata (vtx_wdata),
      .raddr (vtx_raddr),
      .rdata (vtx_rdata)
   );

   assign vtx_rd = vtx_rdata;

   assign v7       = VTX_W'(vert_used);
   assign a_m1     = cmd_ff.vertex_a - VTX_W'(1);
   assign b_m1     = cmd_ff.vertex_b - VTX_W'(1);
   assign edge_ok  = (cmd_ff.vertex_a != '0) && (cmd_ff.vertex_b != '0) &&
                     (cmd_ff.vertex_a <= v7) && (cmd_ff.vertex_b <= v7);
   assign src_ok   = (cmd_ff.vertex_a != '0) && (cmd_ff.vertex_a <= v7);
   assign goal_ok  = cmd_ff.vertex_a < v7;
   assign goal_run = cmd_ff.vertex_a < VTX_W'(runv_ff);
   assign w_wide   = (WEIGHT_BITS + IN_WEIGHT_W)'(cmd_ff.edge_weight);
   assign w_cmd    = w_wide[WEIGHT_BITS-1:0];

   assign issue     = idx_ff < vert_used;
   assign pass_done = !issue && !pvld_ff;

   // saturating weight and distance sum
   assign w_rd     = adj_rdata[WEIGHT_BITS-1:0];
   assign w_inf    = adj_rdata[WEIGHT_BITS];
   assign w_sat    = (SUM_W'(w_rd) > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(w_rd);
   assign sum_full = SUM_W'(best_ff) + SUM_W'(w_rd);
   assign sum_sat  = (sum_full > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum_full);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = clr_rsp_ff ? S_RESULT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (cmd_ff.opcode)
               OP_CLEAR: state_in = S_CLEAR;
               OP_EDGE:  state_in = edge_ok ? S_EDGE2 : S_RESULT;
               OP_RUN:   state_in = src_ok ? S_INIT : S_RESULT;
               OP_QUERY: state_in = (goal_ok && goal_run) ? S_QUERY : S_RESULT;
               default:  state_in = S_RESULT;
            endcase
         end
         S_EDGE2: state_in = S_RESULT;
         S_INIT: begin
            if (pass_done) begin
               state_in = (vert_used > CW'(1)) ? S_SCAN : S_RESULT;
            end
         end
         S_SCAN: begin
            if (pass_done) begin
               state_in = (best_ff == DIST_INF) ? S_RESULT : S_RELAX;
            end
         end
         S_RELAX: begin
            if (pass_done) begin
               state_in = ((round_ff + CW'(1)) < vert_used) ? S_SCAN : S_RESULT;
            end
         end
         S_QUERY: state_in = S_RESULT;
         S_RESULT: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      pidx_in    = idx_ff[VW-1:0];
      pvld_in    = 1'b0;
      src_in     = src_ff;
      pick_in    = pick_ff;
      best_in    = best_ff;
      round_in   = round_ff;
      runv_in    = runv_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      res_in     = res_ff;
      adj_we     = 1'b0;
      adj_waddr  = clr_ff;
      adj_wdata  = ADJ_INF;
      adj_raddr  = {src_ff, idx_ff[VW-1:0]};
      vtx_we     = 1'b0;
      vtx_waddr  = pidx_ff;
      vtx_wdata  = vtx_rd;
      vtx_raddr  = idx_ff[VW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            adj_we = 1'b1;
            clr_in = clr_ff + AW'(1);
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
            end
         end
         S_DECODE: begin
            res_in = '0;
            idx_in = '0;
            clr_in = '0;
            unique case (cmd_ff.opcode)
               OP_CLEAR: clr_rsp_in = 1'b1;
               OP_EDGE: begin
                  if (edge_ok) begin
                     adj_we    = 1'b1;
                     adj_waddr = {a_m1[VW-1:0], b_m1[VW-1:0]};
                     adj_wdata = {1'b0, w_cmd};
                  end else begin
                     res_in.status = STAT_BAD_EDGE;
                  end
               end
               OP_RUN: begin
                  if (src_ok) begin
                     src_in   = a_m1[VW-1:0];
                     runv_in  = vert_used;
                     round_in = CW'(1);
                  end else begin
                     res_in.status = STAT_BAD_VERTEX;
                  end
               end
               OP_QUERY: begin
                  vtx_raddr = cmd_ff.vertex_a[VW-1:0];
                  if (!goal_ok) begin
                     res_in.status = STAT_BAD_VERTEX;
                  end
               end
               default: res_in = '0;
            endcase
         end
         S_EDGE2: begin
            adj_we    = 1'b1;
            adj_waddr = {b_m1[VW-1:0], a_m1[VW-1:0]};
            adj_wdata = {1'b0, w_cmd};
         end
         S_INIT: begin
            adj_raddr = {src_ff, idx_ff[VW-1:0]};
            if (issue) begin
               idx_in  = idx_ff + CW'(1);
               pvld_in = 1'b1;
            end
            if (pvld_ff) begin
               vtx_we            = 1'b1;
               vtx_wdata.visited = (pidx_ff == src_ff);
               vtx_wdata.pred    = PRED_W'(src_ff);
               if (pidx_ff == src_ff) begin
                  vtx_wdata.cost = '0;
               end else begin
                  vtx_wdata.cost = w_inf ? DIST_INF : w_sat;
               end
            end
            if (pass_done) begin
               idx_in  = '0;
               best_in = DIST_INF;
            end
         end
         S_SCAN: begin
            if (issue) begin
               idx_in  = idx_ff + CW'(1);
               pvld_in = 1'b1;
            end
            if (pvld_ff && !vtx_rd.visited && (vtx_rd.cost < best_ff)) begin
               best_in = vtx_rd.cost;
               pick_in = pidx_ff;
            end
            if (pass_done) begin
               idx_in = '0;
            end
         end
         S_RELAX: begin
            adj_raddr = {pick_ff, idx_ff[VW-1:0]};
            if (issue) begin
               idx_in  = idx_ff + CW'(1);
               pvld_in = 1'b1;
            end
            if (pvld_ff) begin
               if (pidx_ff == pick_ff) begin
                  vtx_we            = 1'b1;
                  vtx_wdata.visited = 1'b1;
               end else if (!vtx_rd.visited && !w_inf && (sum_sat < vtx_rd.cost)) begin
                  vtx_we         = 1'b1;
                  vtx_wdata.cost = sum_sat;
                  vtx_wdata.pred = PRED_W'(pick_ff);
               end
            end
            if (pass_done) begin
               idx_in   = '0;
               best_in  = DIST_INF;
               round_in = round_ff + CW'(1);
            end
         end
         S_QUERY: begin
            if (vtx_rd.cost != DIST_INF) begin
               res_in.reachable     = 1'b1;
               res_in.path_distance = vtx_rd.cost[RES_DIST_W-1:0];
               res_in.predecessor   = vtx_rd.pred;
            end
         end
         S_RESULT: res_in = res_ff;
         default: res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         pvld_ff    <= 1'b0;
         runv_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         pvld_ff    <= pvld_in;
         runv_ff    <= runv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      pidx_ff  <= pidx_in;
      src_ff   <= src_in;
      pick_ff  <= pick_in;
      best_ff  <= best_in;
      round_ff <= round_in;
      res_ff   <= res_in;
   end

   assign stat.cmd_ready = (state_ff == S_IDLE);
   assign stat.res_valid = (state_ff == S_RESULT);
   assign res            = res_ff;

endmodule

`default_nettype wire

// ===== sv/dense_dijkstra_shortest_path_top.sv =====
// a run from the source does an init pass, then a scan pass and a relax pass for each of R selected
// vertices (R <= V - 1), ending early with a scan that finds no reachable unvisited vertex;
// the passes are paced by one memory read per cycle
// one item at a time; the next beat is taken while a result waits in the output register
// reset is synchronous; afterwards the matrix clearing pass runs with req_tready low
`default_nettype none
`include "dense_dijkstra_shortest_path_top_macros.svh"

module dense_dijkstra_shortest_path_top #(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // vertex_a[6:0], vertex_b[13:7], edge_weight[29:14]
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // path_distance[20:0], reachable[21], predecessor[27:22]
   output logic      [1:0]  rsp_tuser,   // status[1:0]
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);

   import dds_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic [CSR_W-1:0] cnt_ff, cnt_in;
   logic [CSR_W:0]   cnt_wide;
   logic [CW-1:0]    v_used;
   cmd_type          cmd;
   eng_stat_type     eng_stat;
   res_type          eng_res;
   logic             res_ack;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   res_type          rsp_res_ff, rsp_res_in;

   assign cnt_in   = csr_wr_en ? csr_wr_data : cnt_ff;
   assign cnt_wide = {1'b0, cnt_ff};

   always_comb begin
      if (cnt_ff == '0) begin
         v_used = CW'(1);
      end else if (cnt_wide > (CSR_W + 1)'(MAX_VERTICES)) begin
         v_used = CW'(MAX_VERTICES);
      end else begin
         v_used = CW'(cnt_wide);
      end
   end

   assign cmd.opcode      = opcode_type'(req_tuser);
   assign cmd.vertex_a    = req_tdata[6:0];
   assign cmd.vertex_b    = req_tdata[13:7];
   assign cmd.edge_weight = req_tdata[29:14];

   dds_engine #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd       (cmd),
      .vert_used (v_used),
      .res_ack   (res_ack),
      .stat      (eng_stat),
      .res       (eng_res)
   );

   assign req_tready = eng_stat.cmd_ready;

   // output register
   assign res_ack       = eng_stat.res_valid && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid_in = res_ack || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_res_in    = res_ack ? eng_res : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= VCOUNT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {4'b0000, rsp_res_ff.predecessor, rsp_res_ff.reachable,
                        rsp_res_ff.path_distance};

   `DDS_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "item overlap")
   `DDS_ASSERT_NOW(a_res_excl, clock, reset, eng_stat.res_valid, !req_tready, "result while ready")
   `DDS_ASSERT_NOW(a_clr_pass, clock, reset, $fell(reset), !req_tready, "ready during clear pass")

endmodule

`default_nettype wire
